>>> hdl/linear_probe_hash_index_assert.svh
// assertion macros shared by the hash index rtl
// each macro samples on the rising edge of clk and is off while rst_n is low
`ifndef LINEAR_PROBE_HASH_INDEX_ASSERT_SVH
`define LINEAR_PROBE_HASH_INDEX_ASSERT_SVH

// consequence holds in the same cycle as the antecedent
`define LPHI_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequence holds in the cycle after the antecedent
`define LPHI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/lphi_pkg.sv
// ----------------------------------------------------------------------------
// lphi_pkg
// shared types, codes and constants of the linear probe hash index
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lphi_pkg;

  localparam int KEY_W     = 32;
  localparam int ROW_IN_W  = 16;
  localparam int ROW_OUT_W = 16;
  localparam int MARK_W    = 2;

  localparam int DEF_SLOT_COUNT   = 1024;
  localparam int DEF_ROW_NUM_BITS = 16;

  // xor-shift-multiply mixer constants
  localparam logic [KEY_W-1:0] HASH_MUL_A = 32'h7feb352d;
  localparam logic [KEY_W-1:0] HASH_MUL_B = 32'h846ca68b;
  localparam int HASH_SHIFT_A = 16;
  localparam int HASH_SHIFT_B = 15;

  typedef logic [1:0]        cmd_t;
  typedef logic [1:0]        status_t;
  typedef logic [MARK_W-1:0] mark_t;

  localparam cmd_t CMD_LOOKUP = 2'd0;
  localparam cmd_t CMD_INSERT = 2'd1;
  localparam cmd_t CMD_REMOVE = 2'd2;

  localparam status_t STAT_OK   = 2'd0;
  localparam status_t STAT_MISS = 2'd1;
  localparam status_t STAT_FULL = 2'd2;

  localparam mark_t MARK_EMPTY = 2'd0;
  localparam mark_t MARK_USED  = 2'd1;
  localparam mark_t MARK_GONE  = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MIX1,
    ST_MIX2,
    ST_ISSUE,
    ST_PROBE,
    ST_RESP
  } state_t;

  // finished transaction handed from the controller to the output stage
  typedef struct packed {
    logic                 valid;
    status_t              status;
    logic [ROW_OUT_W-1:0] row;
  } res_t;

endpackage

>>> hdl/lphi_ram.sv
// ----------------------------------------------------------------------------
// lphi_ram
// simple dual port ram, one write port, one read port with registered data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lphi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> hdl/lphi_hash.sv
// ----------------------------------------------------------------------------
// lphi_hash
// two stage xor-shift-multiply key mixer, gives the start slot of a probe
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lphi_hash
  import lphi_pkg::*;
#(
  parameter int SLOT_BITS = 10
) (
  input  logic                 clk,
  input  logic [KEY_W-1:0]     key,
  output logic [SLOT_BITS-1:0] slot
);

  logic [KEY_W-1:0] mul_a_r;
  logic [KEY_W-1:0] mul_b_r;
  logic [KEY_W-1:0] mix_a;
  logic [KEY_W-1:0] mix_b;
  logic [KEY_W-1:0] mix_c;

  assign mix_a = key ^ (key >> HASH_SHIFT_A);
  assign mix_b = mul_a_r ^ (mul_a_r >> HASH_SHIFT_B);
  assign mix_c = mul_b_r ^ (mul_b_r >> HASH_SHIFT_A);

  // low 32 bits of each product
  always_ff @(posedge clk) begin
    mul_a_r <= mix_a * HASH_MUL_A;
    mul_b_r <= mix_b * HASH_MUL_B;
  end

  assign slot = mix_c[SLOT_BITS-1:0];

endmodule

>>> hdl/lphi_ctrl.sv
// ----------------------------------------------------------------------------
// lphi_ctrl
// sequencer for clearing pass, hashing, probe walk and slot update
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lphi_ctrl
  import lphi_pkg::*;
#(
  parameter int SLOT_COUNT   = DEF_SLOT_COUNT,
  parameter int ROW_NUM_BITS = DEF_ROW_NUM_BITS,
  localparam int SLOT_BITS   = $clog2(SLOT_COUNT),
  localparam int ENTRY_W     = MARK_W + ROW_NUM_BITS + KEY_W
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // transaction intake
  input  logic                 in_valid,
  output logic                 in_ready,
  input  cmd_t                 in_command,
  input  logic [KEY_W-1:0]     in_lookup_key,
  input  logic [ROW_IN_W-1:0]  in_row_in,
  // hash unit
  output logic [KEY_W-1:0]     hash_key,
  input  logic [SLOT_BITS-1:0] hash_slot,
  // slot memory
  output logic                 mem_wr_en,
  output logic [SLOT_BITS-1:0] mem_wr_addr,
  output logic [ENTRY_W-1:0]   mem_wr_data,
  output logic [SLOT_BITS-1:0] mem_rd_addr,
  input  logic [ENTRY_W-1:0]   mem_rd_data,
  // result
  output res_t                 res,
  input  logic                 res_ready
);

  state_t state_r, state_nxt;

  logic [SLOT_BITS-1:0]    clr_idx_r;
  cmd_t                    cmd_r;
  logic [KEY_W-1:0]        key_r;
  logic [ROW_NUM_BITS-1:0] row_r;
  logic [SLOT_BITS-1:0]    cur_r;
  logic [SLOT_BITS-1:0]    cnt_r;
  logic                    seen_gone_r;
  logic [SLOT_BITS-1:0]    first_gone_r;
  logic                    hit_r;
  logic                    have_gap_r;
  logic [SLOT_BITS-1:0]    wr_slot_r;
  logic [ROW_OUT_W-1:0]    row_hit_r;

  mark_t                   rd_mark;
  logic [ROW_NUM_BITS-1:0] rd_row;
  logic [KEY_W-1:0]        rd_key;
  logic                    p_empty;
  logic                    p_match;
  logic                    p_gone;
  logic                    p_last;
  logic                    probe_done;
  logic [SLOT_BITS-1:0]    gap_sel;
  logic                    in_take;

  assign rd_mark = mem_rd_data[ENTRY_W-1 -: MARK_W];
  assign rd_row  = mem_rd_data[KEY_W +: ROW_NUM_BITS];
  assign rd_key  = mem_rd_data[KEY_W-1:0];

  assign p_empty    = (rd_mark == MARK_EMPTY);
  assign p_match    = (rd_mark == MARK_USED) && (rd_key == key_r);
  // deleted, or a mark that is never stored, is skipped
  assign p_gone     = (rd_mark != MARK_EMPTY) && (rd_mark != MARK_USED);
  assign p_last     = &cnt_r;
  assign probe_done = p_empty || p_match || p_last;
  assign gap_sel    = seen_gone_r ? first_gone_r : cur_r;
  assign in_take    = in_valid && in_ready;
  assign hash_key   = key_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (&clr_idx_r) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (in_command inside {CMD_LOOKUP, CMD_INSERT, CMD_REMOVE}) begin
            state_nxt = ST_MIX1;
          end else begin
            state_nxt = ST_RESP;
          end
        end
      end
      ST_MIX1:  state_nxt = ST_MIX2;
      ST_MIX2:  state_nxt = ST_ISSUE;
      ST_ISSUE: state_nxt = ST_PROBE;
      ST_PROBE: begin
        if (probe_done) state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (res_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    in_ready    = 1'b0;
    mem_wr_en   = 1'b0;
    mem_wr_addr = wr_slot_r;
    mem_wr_data = {MARK_USED, row_r, key_r};
    mem_rd_addr = cur_r + 1'b1;
    res.valid   = 1'b0;
    res.status  = STAT_MISS;
    res.row     = '0;
    case (state_r)
      ST_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = clr_idx_r;
        mem_wr_data = {MARK_EMPTY, {(ROW_NUM_BITS + KEY_W){1'b0}}};
      end
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_ISSUE: begin
        mem_rd_addr = hash_slot;
      end
      ST_RESP: begin
        res.valid = 1'b1;
        case (cmd_r)
          CMD_LOOKUP: begin
            res.status = hit_r ? STAT_OK : STAT_MISS;
            res.row    = hit_r ? row_hit_r : '0;
          end
          CMD_INSERT: begin
            res.status = (hit_r || have_gap_r) ? STAT_OK : STAT_FULL;
            mem_wr_en  = res_ready && (hit_r || have_gap_r);
          end
          CMD_REMOVE: begin
            res.status  = hit_r ? STAT_OK : STAT_MISS;
            mem_wr_en   = res_ready && hit_r;
            mem_wr_data = {MARK_GONE, row_r, key_r};
          end
          default: begin
            res.status = STAT_MISS;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_idx_r <= clr_idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_r      <= in_command;
      key_r      <= in_lookup_key;
      row_r      <= ROW_NUM_BITS'(in_row_in);
      hit_r      <= 1'b0;
      have_gap_r <= 1'b0;
      row_hit_r  <= '0;
    end
    if (state_r == ST_ISSUE) begin
      cur_r        <= hash_slot;
      cnt_r        <= '0;
      seen_gone_r  <= 1'b0;
      first_gone_r <= '0;
    end
    if (state_r == ST_PROBE) begin
      cur_r <= cur_r + 1'b1;
      cnt_r <= cnt_r + 1'b1;
      if (p_gone && !seen_gone_r) begin
        seen_gone_r  <= 1'b1;
        first_gone_r <= cur_r;
      end
      if (p_match) begin
        hit_r     <= 1'b1;
        wr_slot_r <= cur_r;
        row_hit_r <= ROW_OUT_W'(rd_row);
      end else if (p_empty) begin
        have_gap_r <= 1'b1;
        wr_slot_r  <= gap_sel;
      end else if (p_last) begin
        // every slot visited, no empty one
        have_gap_r <= seen_gone_r || p_gone;
        wr_slot_r  <= gap_sel;
      end
    end
  end

endmodule

>>> hdl/linear_probe_hash_index.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_index
// key to row index in an open addressed table with linear probing
//
// input channel (in_valid / in_ready) carries one transaction: in_command
// (lookup, insert or update, remove), in_lookup_key and in_row_in. the
// output channel (out_valid / out_ready) returns exactly one transaction per
// input: out_status and out_row_out.
// a transaction is hashed in two multiplier stages, then the probe walk reads
// one slot per cycle from the slot ram (one read and one write port); it
// visits 1 to SLOT_COUNT slots. a taken transaction passes the states mix1,
// mix2, issue, probe and resp, and is loaded into the output register from
// resp; the block takes no new transaction until the current one has left
// resp. an unused command goes from idle straight to resp.
// after reset a clearing pass writes every slot empty, one slot per cycle,
// with in_ready low.
// the output register lets the next transaction enter while a result waits;
// when out_ready stays low, the following transaction waits at its final
// step and in_ready stays low until the register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "linear_probe_hash_index_assert.svh"

module linear_probe_hash_index
  import lphi_pkg::*;
#(
  parameter int SLOT_COUNT   = DEF_SLOT_COUNT,
  parameter int ROW_NUM_BITS = DEF_ROW_NUM_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_command,
  input  logic [KEY_W-1:0]     in_lookup_key,
  input  logic [ROW_IN_W-1:0]  in_row_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_status,
  output logic [ROW_OUT_W-1:0] out_row_out
);

  localparam int SLOT_BITS = $clog2(SLOT_COUNT);
  // slot entry: mark, row, key
  localparam int ENTRY_W   = MARK_W + ROW_NUM_BITS + KEY_W;

  logic [KEY_W-1:0]     hash_key;
  logic [SLOT_BITS-1:0] hash_slot;
  logic                 mem_wr_en;
  logic [SLOT_BITS-1:0] mem_wr_addr;
  logic [ENTRY_W-1:0]   mem_wr_data;
  logic [SLOT_BITS-1:0] mem_rd_addr;
  logic [ENTRY_W-1:0]   mem_rd_data;
  res_t                 res;
  logic                 res_ready;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  status_t              out_status_r;
  logic [ROW_OUT_W-1:0] out_row_r;
  logic                 res_load;

  lphi_hash #(
    .SLOT_BITS (SLOT_BITS)
  ) u_hash (
    .clk  (clk),
    .key  (hash_key),
    .slot (hash_slot)
  );

  lphi_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOT_COUNT)
  ) u_slots (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  lphi_ctrl #(
    .SLOT_COUNT   (SLOT_COUNT),
    .ROW_NUM_BITS (ROW_NUM_BITS)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_command    (in_command),
    .in_lookup_key (in_lookup_key),
    .in_row_in     (in_row_in),
    .hash_key      (hash_key),
    .hash_slot     (hash_slot),
    .mem_wr_en     (mem_wr_en),
    .mem_wr_addr   (mem_wr_addr),
    .mem_wr_data   (mem_wr_data),
    .mem_rd_addr   (mem_rd_addr),
    .mem_rd_data   (mem_rd_data),
    .res           (res),
    .res_ready     (res_ready)
  );

  // the register is free when empty or drained this cycle
  assign res_ready = !out_valid_r || out_ready;
  assign res_load  = res.valid && res_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_status_r <= res.status;
      out_row_r    <= res.row;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_row_out = out_row_r;

  // one transaction in flight: intake closes right after a take
  `LPHI_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "intake still open after take")

  // the controller never offers a result while it is open for intake
  `LPHI_ASSERT_SAME(a_no_res_idle, in_ready, !res.valid, "result offered while idle")

  // a result handed over shows up on the output channel next cycle
  `LPHI_ASSERT_NEXT(a_res_to_out, res.valid && res_ready, out_valid, "result lost at output register")

  // only a hit carries a row number
  `LPHI_ASSERT_SAME(a_row_zero, out_valid && (out_status != STAT_OK), out_row_out == '0, "row on non hit")

endmodule
